// ===== src/spq_pkg.sv =====
// shared types and constants for the sorted array priority queue
`timescale 1ns / 1ps

package spq_pkg;

  // default geometry
  localparam int DEPTH_DEF = 16;
  localparam int KEY_W_DEF = 32;

  // capacity register
  localparam int          CAP_W     = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  // command codes, the fourth code is a no-op
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PEEK   = 2'd2
  } cmd_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;  // insert carried out this cycle
    logic rem;  // remove carried out this cycle
  } spq_ctl_t;

endpackage

// ===== src/sorted_array_priority_queue.sv =====
// top level of the sorted array priority queue: command decode, cell row, result register
//
//  channel  | direction | fields (low bit first)
//  in_*     | slave     | tdata: command[1:0], key_value[KEY_WIDTH-1:0], zero fill
//  out_*    | master    | tdata: success, head_value, stored_count, is_empty, is_full, zero fill
//  cfg_*    | write     | wdata: capacity_limit[4:0]
//
// For every command the whole row compares and shifts in the cycle
// the transaction is accepted, and the result sits in the output register the next.
// A new command is taken when no result waits or in the cycle the previous result is taken.
// Reset clears the count, the result valid and sets the capacity to 16; keys hold
// whatever they held until written. Output stalls block input once the result register is full.
`timescale 1ns / 1ps

module sorted_array_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = spq_pkg::KEY_W_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int IN_W     = ((KEY_WIDTH + 2 + 7) / 8) * 8,
  localparam int OUT_W    = ((KEY_WIDTH + CNT_W + 3 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command in
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_W-1:0]           in_tdata,   // command, key_value
  // result out
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // success, head_value, stored_count, is_empty, is_full
  // capacity register
  input  logic                      cfg_we,
  input  logic [spq_pkg::CAP_W-1:0] cfg_wdata   // capacity_limit
);

  localparam int CMP_W  = (CNT_W > spq_pkg::CAP_W) ? CNT_W : spq_pkg::CAP_W;
  localparam int RES_W  = KEY_WIDTH + CNT_W + 3;

  logic [spq_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic [OUT_W-1:0]          out_data_r;

  logic                      in_acc;
  logic [1:0]                cmd;
  logic [KEY_WIDTH-1:0]      key;
  logic                      full_now;
  logic                      empty_now;
  logic                      full_after;
  logic                      ok;
  logic                      take_head;
  spq_pkg::spq_ctl_t         ctl;
  logic [KEY_WIDTH-1:0]      head;
  logic [RES_W-1:0]          res;

  logic [KEY_WIDTH-1:0]      cell_key [DEPTH];
  logic                      cell_lt  [DEPTH];

  // handshake
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign cmd        = in_tdata[1:0];
  assign key        = in_tdata[KEY_WIDTH+1:2];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // occupancy flags before the command
  assign empty_now = (count_r == '0);
  assign full_now  = (CMP_W'(count_r) >= CMP_W'(cap_r)) || (count_r == CNT_W'(DEPTH));

  // command decode
  always_comb begin
    ctl       = '0;
    ok        = 1'b0;
    take_head = 1'b0;
    count_nxt = count_r;
    case (cmd)
      spq_pkg::CMD_INSERT: begin
        ok        = !full_now;
        ctl.ins   = in_acc && !full_now;
        count_nxt = full_now ? count_r : count_r + CNT_W'(1);
      end
      spq_pkg::CMD_REMOVE: begin
        ok        = !empty_now;
        take_head = !empty_now;
        ctl.rem   = in_acc && !empty_now;
        count_nxt = empty_now ? count_r : count_r - CNT_W'(1);
      end
      spq_pkg::CMD_PEEK: begin
        ok        = !empty_now;
        take_head = !empty_now;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // result fields after the command
  assign full_after = (CMP_W'(count_nxt) >= CMP_W'(cap_r)) || (count_nxt == CNT_W'(DEPTH));
  assign head       = take_head ? cell_key[0] : '0;
  assign res        = {full_after, (count_nxt == '0), count_nxt, head, ok};

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 lt_left;
    logic [KEY_WIDTH-1:0] left_key;
    logic [KEY_WIDTH-1:0] right_key;

    if (i == 0) begin : g_first
      assign lt_left  = 1'b1;
      assign left_key = key;
    end else begin : g_mid
      assign lt_left  = cell_lt[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_key  (key),
      .active   (CNT_W'(i) < count_r),
      .lt_prev  (lt_left),
      .prev_key (left_key),
      .next_key (right_key),
      .lt_o     (cell_lt[i]),
      .key_o    (cell_key[i])
    );
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= spq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= OUT_W'(res);
    end
  end

`ifndef NO_ASSERTIONS
  // count never runs past the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a successful insert grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance count");

  // a successful remove reports the old head and shrinks the count
  a_remove_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem |=> (out_data_r[KEY_WIDTH:1] == $past(cell_key[0])) &&
                (count_r == $past(count_r) - CNT_W'(1)))
    else $error("remove result mismatch");

  // the two smallest entries stay in order
  a_sorted_front: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> cell_key[0] <= cell_key[1])
    else $error("front of row out of order");
`endif

endmodule

// ===== src/spq_cell.sv =====
// one cell of the sorted key row: holds one key and shifts with its neighbors
`timescale 1ns / 1ps

module spq_cell #(
  parameter int KEY_WIDTH = spq_pkg::KEY_W_DEF
) (
  input  logic                 clk,
  input  spq_pkg::spq_ctl_t    ctl,
  input  logic [KEY_WIDTH-1:0] new_key,    // key being inserted
  input  logic                 active,     // cell holds a stored entry
  input  logic                 lt_prev,    // new key sorts after the left cell
  input  logic [KEY_WIDTH-1:0] prev_key,   // left neighbor's key
  input  logic [KEY_WIDTH-1:0] next_key,   // right neighbor's key
  output logic                 lt_o,       // new key sorts after this cell
  output logic [KEY_WIDTH-1:0] key_o
);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;

  // new key passes this entry only if strictly larger
  assign lt_o  = active && (new_key > key_r);
  assign key_o = key_r;

  // keep, take the new key, or shift from a neighbor
  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      if (lt_o) begin
        key_nxt = key_r;
      end else if (lt_prev) begin
        key_nxt = new_key;
      end else begin
        key_nxt = prev_key;
      end
    end else if (ctl.rem) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
